/* rtl/c3br_pkg.sv */
// c3br_pkg: shared types, widths and register codes of the 3x3 convolution unit
// no dependencies; imported by the interfaces, c3br_cell and the top level
`timescale 1ns / 1ps

package c3br_pkg;

    localparam int KSIZE          = 3;
    localparam int PIX_W          = 16;
    localparam int WT_W           = 16;
    localparam int RES_W          = 15;
    localparam int PROD_W         = 2 * PIX_W;
    localparam int COL_W          = PROD_W + 2;
    localparam int ACC_W          = PROD_W + 4;
    localparam int BIAS_W         = 32;
    localparam int ROW_W          = KSIZE * WT_W;
    localparam int DIM_W          = 11;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = ROW_W;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int DIM_RESET      = 8;
    localparam int FRAC_DROP      = 12;
    localparam int ROUND_HALF     = 1 << (FRAC_DROP - 1);
    localparam int RES_MAX        = (1 << RES_W) - 1;

    typedef logic signed [PIX_W-1:0]  pix_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COL_W-1:0]  colsum_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHTS_ROW0 = 3'd0,
        CFG_WEIGHTS_ROW1 = 3'd1,
        CFG_WEIGHTS_ROW2 = 3'd2,
        CFG_BIAS_VALUE   = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } cfg_index_t;

    // window cell control: shift takes a new column, advance moves the mac stages
    typedef struct packed {
        logic shift;
        logic advance;
    } cell_ctrl_t;

endpackage

/* rtl/c3br_pix_if.sv */
// c3br_pix_if: pixel request channel (valid/ready, pixel, frame_start)
// depends on c3br_pkg
`timescale 1ns / 1ps

interface c3br_pix_if;
    import c3br_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

/* rtl/c3br_res_if.sv */
// c3br_res_if: result request channel (valid/ready, result, frame_last)
// depends on c3br_pkg
`timescale 1ns / 1ps

interface c3br_res_if;
    import c3br_pkg::*;

    logic             valid;
    logic             ready;
    logic [RES_W-1:0] result;
    logic             frame_last;

    modport source (output valid, output result, output frame_last, input ready);
    modport sink (input valid, input result, input frame_last, output ready);
endinterface

/* rtl/c3br_cfg_if.sv */
// c3br_cfg_if: register write channel (valid/ready, index, data)
// depends on c3br_pkg
`timescale 1ns / 1ps

interface c3br_cfg_if;
    import c3br_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/c3br_ram.sv */
// c3br_ram: generic single-write, single-read ram with registered read data
// no dependencies; a write to the address being read returns the new data
`timescale 1ns / 1ps

module c3br_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= (we && (waddr == raddr)) ? wdata : mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/c3br_cell.sv */
// c3br_cell: one window column (three pixels) with its three multipliers and column sum
// depends on c3br_pkg; chained by the top level, right cell takes the new column
`timescale 1ns / 1ps

module c3br_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  c3br_pkg::cell_ctrl_t ctrl,
    input  c3br_pkg::pix_t      col_in [c3br_pkg::KSIZE],
    input  c3br_pkg::pix_t      wt [c3br_pkg::KSIZE],
    output c3br_pkg::pix_t      col_out [c3br_pkg::KSIZE],
    output c3br_pkg::colsum_t   colsum
);
    import c3br_pkg::*;

    pix_t    pix_reg [KSIZE];
    prod_t   prod_reg [KSIZE];
    colsum_t colsum_reg;

    // window pixels, handed to the left neighbor on every shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < KSIZE; r++)
            begin
                pix_reg[r] <= '0;
            end
        end
        else if (ctrl.shift)
        begin
            for (int r = 0; r < KSIZE; r++)
            begin
                pix_reg[r] <= col_in[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int r = 0; r < KSIZE; r++)
            begin
                prod_reg[r] <= PROD_W'(pix_reg[r] * wt[r]);
            end
            colsum_reg <= COL_W'(prod_reg[0]) + COL_W'(prod_reg[1]) + COL_W'(prod_reg[2]);
        end
    end

    assign col_out = pix_reg;
    assign colsum  = colsum_reg;
endmodule

/* rtl/conv3x3_bias_relu_unit.sv */
// conv3x3_bias_relu_unit: streaming 3x3 convolution, bias and relu, valid padding
// depends on c3br_pkg, c3br_pix_if, c3br_res_if, c3br_cfg_if, c3br_ram, c3br_cell
`timescale 1ns / 1ps

// usage
//   pixel_stream: signed q8.8 pixels in raster order; frame_start on a request
//     clears the column and row counters before that pixel is taken
//   result_stream: one request per fully covered 3x3 window, relu of the sum
//     plus bias, rounded to q8.8 and saturated to 0..32767; frame_last marks the
//     last window of the frame, (width-2)*(height-2) results per frame
//   cfg: register writes (weights rows 0..2, bias, width, height), always ready;
//     write only while the block is idle
// throughput: one pixel per cycle while the skid entry is free; set by the line
//   store ram ports, which read and write one entry each per pixel
// path: after its pixel is taken, a result passes the line store read, window
//   shift, products, column sums, total and output register
// reset: counters, window and registers clear (width and height read 8); the
//   line stores are not cleared and need no clearing pass, so the block takes
//   pixels in the first cycle after reset
// stall: an output register plus one skid entry; the pipeline keeps moving
//   while a result waits and freezes only when the skid entry is also full
module conv3x3_bias_relu_unit #(
    parameter int MAX_WIDTH  = c3br_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = c3br_pkg::MAX_HEIGHT_DEF
) (
    input logic         clk,
    input logic         rst_n,
    c3br_pix_if.sink    pixel_stream,
    c3br_res_if.source  result_stream,
    c3br_cfg_if.sink    cfg
);
    import c3br_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int DW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int SH_W = ACC_W - FRAC_DROP;

    // configuration registers
    logic [ROW_W-1:0]         wrow_reg [KSIZE];
    logic signed [BIAS_W-1:0] bias_reg;
    logic [DIM_W-1:0]         image_width_reg;
    logic [DIM_W-1:0]         image_height_reg;

    // position counters
    logic [XW-1:0] col_cnt_reg;
    logic [YW-1:0] row_cnt_reg;

    // pipeline
    logic          s1_valid_reg;
    logic          s1_produce_reg;
    logic          s1_last_reg;
    pix_t          s1_px_reg;
    logic [XW-1:0] s1_x_reg;
    logic          s2_valid_reg;
    logic          s2_last_reg;
    logic          s3_valid_reg;
    logic          s3_last_reg;
    logic          s4_valid_reg;
    logic          s4_last_reg;
    logic          s5_valid_reg;
    logic          s5_last_reg;
    acc_t          s5_acc_reg;

    // output register and skid entry
    logic             out_valid_reg;
    logic [RES_W-1:0] out_result_reg;
    logic             out_last_reg;
    logic             skid_valid_reg;
    logic [RES_W-1:0] skid_result_reg;
    logic             skid_last_reg;

    logic          advance;
    logic          accept;
    logic          take;
    logic          push;
    logic [DW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [XW-1:0] x_cur;
    logic [YW-1:0] y_cur;
    logic [DW-1:0] x_ext;
    logic [HW-1:0] y_ext;
    logic [DW-1:0] x_inc;
    logic [HW-1:0] y_inc;
    logic          produce;
    logic          last_win;
    logic [XW-1:0] col_cnt_next;
    logic [YW-1:0] row_cnt_next;
    logic          cfg_we;

    pix_t             above;
    pix_t             above2;
    pix_t             new_col [KSIZE];
    pix_t             col_out [KSIZE][KSIZE];
    colsum_t          colsum [KSIZE];
    cell_ctrl_t       cell_ctrl;
    acc_t             rnd;
    logic [SH_W-1:0]  shifted;
    logic [RES_W-1:0] res_value;

    // pipeline moves whenever the skid entry is free
    assign advance = !skid_valid_reg;
    assign accept  = pixel_stream.valid && advance;
    assign take    = out_valid_reg && result_stream.ready;
    assign push    = advance && s5_valid_reg;
    assign cfg_we  = cfg.valid;

    assign pixel_stream.ready = advance;
    assign cfg.ready          = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < KSIZE; r++)
            begin
                wrow_reg[r] <= '0;
            end
            bias_reg         <= '0;
            image_width_reg  <= DIM_W'(DIM_RESET);
            image_height_reg <= DIM_W'(DIM_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg.index)
                CFG_WEIGHTS_ROW0: wrow_reg[0]      <= cfg.data[ROW_W-1:0];
                CFG_WEIGHTS_ROW1: wrow_reg[1]      <= cfg.data[ROW_W-1:0];
                CFG_WEIGHTS_ROW2: wrow_reg[2]      <= cfg.data[ROW_W-1:0];
                CFG_BIAS_VALUE:   bias_reg         <= cfg.data[BIAS_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg.data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg.data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // frame size clamped to 3..max
    always_comb
    begin
        if (image_width_reg < DIM_W'(KSIZE))
        begin
            w_eff = DW'(KSIZE);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = DW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = DW'(image_width_reg);
        end

        if (image_height_reg < DIM_W'(KSIZE))
        begin
            h_eff = HW'(KSIZE);
        end
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(image_height_reg);
        end
    end

    // ---------------- position and window decision ----------------
    always_comb
    begin
        x_cur    = pixel_stream.frame_start ? '0 : col_cnt_reg;
        y_cur    = pixel_stream.frame_start ? '0 : row_cnt_reg;
        x_ext    = DW'(x_cur);
        y_ext    = HW'(y_cur);
        x_inc    = x_ext + DW'(1);
        y_inc    = y_ext + HW'(1);
        produce  = (x_ext >= DW'(KSIZE - 1)) && (y_ext >= HW'(KSIZE - 1))
                   && (x_ext < w_eff) && (y_ext < h_eff);
        last_win = (x_inc == w_eff) && (y_inc == h_eff);

        // wrap at end of line, and at end of frame
        if (x_inc >= w_eff)
        begin
            col_cnt_next = '0;
            row_cnt_next = (y_inc >= h_eff) ? '0 : y_inc[YW-1:0];
        end
        else
        begin
            col_cnt_next = x_inc[XW-1:0];
            row_cnt_next = y_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ---------------- line stores ----------------
    // store a holds the line above, store b the line two above; read at accept,
    // written back when the pixel leaves stage 1
    c3br_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .clk   (clk),
        .we    (cell_ctrl.shift),
        .waddr (s1_x_reg),
        .wdata (s1_px_reg),
        .re    (accept),
        .raddr (x_cur),
        .rdata (above)
    );

    c3br_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .clk   (clk),
        .we    (cell_ctrl.shift),
        .waddr (s1_x_reg),
        .wdata (above),
        .re    (accept),
        .raddr (x_cur),
        .rdata (above2)
    );

    // ---------------- window cells ----------------
    assign cell_ctrl.shift   = advance && s1_valid_reg;
    assign cell_ctrl.advance = advance;

    // new right column, kernel rows 0..2
    assign new_col[0] = above2;
    assign new_col[1] = above;
    assign new_col[2] = s1_px_reg;

    for (genvar c = 0; c < KSIZE; c++)
    begin : g_cell
        pix_t cin [KSIZE];
        pix_t wt [KSIZE];

        for (genvar r = 0; r < KSIZE; r++)
        begin : g_wt
            assign wt[r] = $signed(wrow_reg[r][WT_W*c +: WT_W]);
        end

        if (c == KSIZE - 1)
        begin : g_right
            assign cin = new_col;
        end
        else
        begin : g_inner
            assign cin = col_out[c+1];
        end

        c3br_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .col_in  (cin),
            .wt      (wt),
            .col_out (col_out[c]),
            .colsum  (colsum[c])
        );
    end

    // ---------------- stage tracking ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pixel_stream.valid;
            s2_valid_reg <= s1_valid_reg && s1_produce_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg      <= pix_t'(pixel_stream.pixel);
            s1_x_reg       <= x_cur;
            s1_produce_reg <= produce;
            s1_last_reg    <= last_win;
        end
        if (advance)
        begin
            s2_last_reg <= s1_last_reg;
            s3_last_reg <= s2_last_reg;
            s4_last_reg <= s3_last_reg;
            s5_last_reg <= s4_last_reg;
            s5_acc_reg  <= ACC_W'(bias_reg) + ACC_W'(colsum[0]) + ACC_W'(colsum[1])
                           + ACC_W'(colsum[2]);
        end
    end

    // relu, round half up to q8.8, saturate
    always_comb
    begin
        rnd     = s5_acc_reg + ACC_W'(ROUND_HALF);
        shifted = rnd[ACC_W-1:FRAC_DROP];
        if (s5_acc_reg[ACC_W-1] || (s5_acc_reg == '0))
        begin
            res_value = '0;
        end
        else if (shifted > SH_W'(RES_MAX))
        begin
            res_value = RES_W'(RES_MAX);
        end
        else
        begin
            res_value = shifted[RES_W-1:0];
        end
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_result_reg <= res_value;
                out_last_reg   <= s5_last_reg;
            end
            else
            begin
                skid_result_reg <= res_value;
                skid_last_reg   <= s5_last_reg;
            end
        end
        else if (take && skid_valid_reg)
        begin
            out_result_reg <= skid_result_reg;
            out_last_reg   <= skid_last_reg;
        end
    end

    assign result_stream.valid      = out_valid_reg;
    assign result_stream.result     = out_result_reg;
    assign result_stream.frame_last = out_last_reg;
endmodule

/* rtl/c3br_checker.sv */
// c3br_checker: port-level assertions for conv3x3_bias_relu_unit, bound to the top level
// depends on conv3x3_bias_relu_unit and its channel interfaces
`timescale 1ns / 1ps

module c3br_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] out_result,
    input logic        out_last
);
    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_last))
        else $error("result changed while stalled");

    // input only stalls while a result is waiting
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // taking a result always frees room for the next pixel
    a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready)
        else $error("input stalled after a result was taken");

    // nothing shown right after reset
    a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result shown right after reset");
endmodule

bind conv3x3_bias_relu_unit c3br_checker u_c3br_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pixel_stream.valid),
    .in_ready   (pixel_stream.ready),
    .out_valid  (result_stream.valid),
    .out_ready  (result_stream.ready),
    .out_result (result_stream.result),
    .out_last   (result_stream.frame_last)
);

/* tb/sv/conv3x3_bias_relu_unit_tb.sv */
// conv3x3_bias_relu_unit_tb: self-checking bench for the streaming 3x3 convolution unit
// depends on c3br_pkg, c3br_pix_if, c3br_res_if, c3br_cfg_if and conv3x3_bias_relu_unit
// a bit-exact predictor runs beside the block and every result request is checked in order
`timescale 1ns / 1ps

module conv3x3_bias_relu_unit_tb;
    import c3br_pkg::*;

    // generous run limit: the slowest correct run stays far below it
    localparam int CYCLE_LIMIT  = 200000;
    // longest wait for outstanding results before they count as lost
    localparam int DRAIN_LIMIT  = 4000;
    // quiet cycles after the last result, covers the pipeline
    localparam int PIPE_SETTLE  = 12;
    localparam int REPORT_LINES = 40;

    typedef struct packed {
        logic [RES_W-1:0] result;
        logic             frame_last;
    } conv_out_t;

    // how a frame's pixels are filled
    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_FLAT,
        FILL_CENTER
    } fill_t;

    logic clk = 1'b0;
    logic rst_n;

    c3br_pix_if pix_if ();
    c3br_res_if res_if ();
    c3br_cfg_if cfg_if ();

    conv3x3_bias_relu_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_stream  (pix_if),
        .result_stream (res_if),
        .cfg           (cfg_if)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: own copy of registers, line stores, window, counters
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]  kernel_rows [KSIZE];
    logic [BIAS_W-1:0] bias_word;
    logic [DIM_W-1:0]  width_word;
    logic [DIM_W-1:0]  height_word;
    logic [PIX_W-1:0]  line_prev1 [MAX_WIDTH_DEF];   // line y-1
    logic [PIX_W-1:0]  line_prev2 [MAX_WIDTH_DEF];   // line y-2
    logic [PIX_W-1:0]  win_m [KSIZE][KSIZE];         // [kernel row][column]
    int                col_pos;
    int                row_pos;

    // results still owed by the block, oldest first
    conv_out_t pending_results [$];
    conv_out_t head_want;

    int  cycle_count   = 0;
    int  err_count     = 0;
    int  pixels_sent   = 0;
    int  results_seen  = 0;
    int  frame_ends    = 0;
    int  cfg_writes    = 0;
    bit  idle_on       = 1'b1;
    int  stall_left    = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    task automatic clear_model();
        int i;
        int j;
        for (i = 0; i < KSIZE; i++)
        begin
            kernel_rows[i] = '0;
            for (j = 0; j < KSIZE; j++)
                win_m[i][j] = '0;
        end
        for (i = 0; i < MAX_WIDTH_DEF; i++)
        begin
            line_prev1[i] = '0;
            line_prev2[i] = '0;
        end
        bias_word   = '0;
        width_word  = DIM_W'(DIM_RESET);
        height_word = DIM_W'(DIM_RESET);
        col_pos     = 0;
        row_pos     = 0;
    endtask

    // sizes outside 3..max are clamped
    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int hi);
        if (v < KSIZE)
            return KSIZE;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic void apply_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_WEIGHTS_ROW0: kernel_rows[0] = d;
            CFG_WEIGHTS_ROW1: kernel_rows[1] = d;
            CFG_WEIGHTS_ROW2: kernel_rows[2] = d;
            CFG_BIAS_VALUE:   bias_word      = d[BIAS_W-1:0];
            CFG_IMAGE_WIDTH:  width_word     = d[DIM_W-1:0];
            CFG_IMAGE_HEIGHT: height_word    = d[DIM_W-1:0];
            default: ;
        endcase
    endfunction

    // takes one pixel, returns 1 when a window result is due
    function automatic bit conv_predict(input logic [PIX_W-1:0] px, input bit fs,
                                        output conv_out_t o);
        int          w;
        int          h;
        int          xc;
        int          yc;
        int          i;
        int          j;
        logic [PIX_W-1:0] up1;
        logic [PIX_W-1:0] up2;
        longint      acc;
        bit          hit;
        w = eff_dim(width_word, MAX_WIDTH_DEF);
        h = eff_dim(height_word, MAX_HEIGHT_DEF);
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        xc = col_pos;
        yc = row_pos;
        // line stores: read the two lines above, then move this column down
        up1 = line_prev1[xc];
        up2 = line_prev2[xc];
        line_prev2[xc] = up1;
        line_prev1[xc] = px;
        // window moves left and takes the new column on the right
        for (i = 0; i < KSIZE; i++)
        begin
            win_m[i][0] = win_m[i][1];
            win_m[i][1] = win_m[i][2];
        end
        win_m[0][2] = up2;
        win_m[1][2] = up1;
        win_m[2][2] = px;
        o   = '0;
        hit = (xc >= 2) && (yc >= 2) && (xc < w) && (yc < h);
        if (hit)
        begin
            acc = longint'($signed(bias_word));
            for (i = 0; i < KSIZE; i++)
                for (j = 0; j < KSIZE; j++)
                    acc += longint'($signed(win_m[i][j])) *
                           longint'($signed(kernel_rows[i][WT_W*j +: WT_W]));
            // relu, round half up to q8.8, saturate
            if (acc <= 0)
                o.result = '0;
            else
            begin
                acc = (acc + ROUND_HALF) >>> FRAC_DROP;
                if (acc > RES_MAX)
                    acc = RES_MAX;
                o.result = acc[RES_W-1:0];
            end
            o.frame_last = (xc == w - 1) && (yc == h - 1);
        end
        // counters wrap at the end of a line and of a frame
        if (xc + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (yc + 1 >= h) ? 0 : yc + 1;
        end
        else
            col_pos = xc + 1;
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (err_count < REPORT_LINES)
            $display("[cycle %0d] mismatch: %s", cycle_count, msg);
        err_count++;
    endtask

    // each result request is compared with the oldest pending result
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (res_if.frame_last === 1'b1)
                frame_ends++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %0d frame_last %0b with none pending",
                                          res_if.result, res_if.frame_last));
            else
            begin
                head_want = pending_results.pop_front();
                if (res_if.result !== head_want.result)
                    report_mismatch($sformatf("result got %0d want %0d",
                                              res_if.result, head_want.result));
                if (res_if.frame_last !== head_want.frame_last)
                    report_mismatch($sformatf("frame_last got %0b want %0b (result %0d)",
                                              res_if.frame_last, head_want.frame_last,
                                              head_want.result));
            end
        end
    end

    // result side back-pressure: random stall bursts of random length
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_if.ready = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 99) < 10)
        begin
            stall_left   = $urandom_range(1, 8) - 1;
            res_if.ready = 1'b0;
        end
        else
            res_if.ready = 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // one pixel request, with an optional idle burst in front of it
    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit fs);
        int        gap;
        conv_out_t o;
        if (idle_on && $urandom_range(0, 99) < 12)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            pix_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pix_if.valid       = 1'b1;
        pix_if.pixel       = px;
        pix_if.frame_start = fs;
        do @(posedge clk); while (!pix_if.ready);
        if (conv_predict(px, fs, o))
            pending_results.push_back(o);
        pixels_sent++;
    endtask

    // register write request; valid stays up until cfg_release
    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = d;
        do @(posedge clk); while (!cfg_if.ready);
        apply_cfg(idx, d);
        cfg_writes++;
    endtask

    task automatic cfg_release();
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // block idle: no results owed and the pipeline has emptied
    task automatic wait_idle();
        int guard;
        guard = 0;
        @(negedge clk);
        pix_if.valid = 1'b0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // writes every register; bits above each field are random and must be ignored
    task automatic set_kernel(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                              input logic [ROW_W-1:0] r2, input logic [BIAS_W-1:0] bias,
                              input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        logic [CFG_DATA_W-1:0] junk;
        junk = {16'($urandom), 32'($urandom)};
        cfg_write(CFG_WEIGHTS_ROW0, r0);
        cfg_write(CFG_WEIGHTS_ROW1, r1);
        cfg_write(CFG_WEIGHTS_ROW2, r2);
        cfg_write(CFG_BIAS_VALUE, {junk[CFG_DATA_W-1:BIAS_W], bias});
        cfg_write(CFG_IMAGE_WIDTH, {junk[CFG_DATA_W-1:DIM_W], w});
        cfg_write(CFG_IMAGE_HEIGHT, {junk[CFG_DATA_W-1:DIM_W], h});
        cfg_release();
    endtask

    // ------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------
    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 3))
            0, 1: return PIX_W'($urandom);
            2: return PIX_W'($urandom_range(0, 1023) - 512);
            default:
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return 16'hffff;
                    default: return 16'h0001;
                endcase
        endcase
    endfunction

    // mostly weights within +-1 so sums stay in range, sometimes anything
    function automatic logic [ROW_W-1:0] rand_weight_row();
        if ($urandom_range(0, 3) == 0)
            return {16'($urandom), 32'($urandom)};
        return {16'($urandom_range(0, 8191) - 4096), 16'($urandom_range(0, 8191) - 4096),
                16'($urandom_range(0, 8191) - 4096)};
    endfunction

    function automatic logic [BIAS_W-1:0] rand_bias();
        if ($urandom_range(0, 4) == 0)
            return BIAS_W'($urandom);
        return BIAS_W'($urandom_range(0, 1 << 26) - (1 << 25));
    endfunction

    // small frames keep results frequent; sometimes a size below 3 that clamps
    function automatic logic [DIM_W-1:0] rand_dim();
        if ($urandom_range(0, 9) == 0)
            return DIM_W'($urandom_range(0, 2));
        return DIM_W'($urandom_range(3, 10));
    endfunction

    task automatic send_frame(input int n, input bit fs_first, input fill_t fill,
                              input logic [PIX_W-1:0] value);
        int               i;
        logic [PIX_W-1:0] px;
        for (i = 0; i < n; i++)
        begin
            case (fill)
                FILL_FLAT:   px = value;
                FILL_CENTER: px = (i == 4) ? value : rand_pixel();
                default:     px = rand_pixel();
            endcase
            send_pixel(px, fs_first && (i == 0));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // registers at reset: zero kernel and bias, 8x8 frame, so every result is 0
    task automatic test_reset_state();
        logic [PIX_W-1:0] pats [6];
        int               i;
        pats = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h5555, 16'haaaa};
        for (i = 0; i < 24; i++)
            send_pixel((i < 6) ? pats[i] : rand_pixel(), i == 0);
        wait_idle();
    endtask

    // half weight in the center only: exercises round half up and relu;
    // frames after the first follow without frame_start
    task automatic test_rounding_and_wrap();
        set_kernel('0, {16'h0000, 16'h0800, 16'h0000}, '0, '0, 11'd3, 11'd3);
        send_frame(9, 1'b1, FILL_CENTER, 16'h0001);
        send_frame(9, 1'b0, FILL_CENTER, 16'h0003);
        send_frame(9, 1'b0, FILL_CENTER, 16'hffff);
        send_frame(9, 1'b0, FILL_CENTER, 16'h7fff);
        wait_idle();
        // bias of minus one lsb pulls an exact half below the rounding point
        set_kernel('0, {16'h0000, 16'h0800, 16'h0000}, '0, 32'hffff_ffff, 11'd3, 11'd3);
        send_frame(9, 1'b1, FILL_CENTER, 16'h0001);
        send_frame(9, 1'b0, FILL_CENTER, 16'h0002);
        wait_idle();
    endtask

    // most negative and most positive weights, bias and pixels; sizes below 3 clamp
    task automatic test_saturation_extremes();
        set_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 32'h7fff_ffff, 11'd0, 11'd2);
        send_frame(9, 1'b1, FILL_FLAT, 16'h8000);
        send_frame(9, 1'b0, FILL_FLAT, 16'h7fff);
        wait_idle();
        set_kernel({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, 32'h8000_0000, 11'd2, 11'd1);
        send_frame(9, 1'b1, FILL_FLAT, 16'h7fff);
        send_frame(9, 1'b0, FILL_FLAT, 16'h0000);
        send_frame(9, 1'b0, FILL_FLAT, 16'h8000);
        wait_idle();
    endtask

    // the frame shrinks while a line is in progress: counters past the new
    // bound give no result; the column wraps at the next step, the row at the end of its line
    task automatic test_resize_midframe();
        set_kernel(rand_weight_row(), rand_weight_row(), rand_weight_row(), rand_bias(),
                   11'd6, 11'd6);
        send_frame(22, 1'b1, FILL_RANDOM, '0);    // stops at row 3, column 4
        wait_idle();
        cfg_write(CFG_IMAGE_WIDTH, 48'd4);
        cfg_release();
        send_frame(6, 1'b0, FILL_RANDOM, '0);     // now at row 5, column 1
        wait_idle();
        cfg_write(CFG_IMAGE_HEIGHT, 48'd4);
        cfg_release();
        send_frame(19, 1'b0, FILL_RANDOM, '0);
        wait_idle();
    endtask

    // frame_start in the middle of a frame restarts the counters
    task automatic test_frame_restart();
        set_kernel(rand_weight_row(), rand_weight_row(), rand_weight_row(), rand_bias(),
                   11'd5, 11'd4);
        send_frame(12, 1'b1, FILL_RANDOM, '0);
        send_frame(20, 1'b1, FILL_RANDOM, '0);
        send_frame(20, 1'b0, FILL_RANDOM, '0);
        wait_idle();
    endtask

    // sizes above the maximum clamp to 1024: one full line at the clamped width
    // must wrap to the next line, which a narrowed frame then finishes with a result
    task automatic test_size_clamp();
        set_kernel(rand_weight_row(), rand_weight_row(), rand_weight_row(), rand_bias(),
                   11'd2047, 11'd2047);
        send_frame(MAX_WIDTH_DEF, 1'b1, FILL_RANDOM, '0);
        wait_idle();
        cfg_write(CFG_IMAGE_WIDTH, 48'd3);
        cfg_release();
        send_frame(2 * KSIZE, 1'b0, FILL_RANDOM, '0);
        wait_idle();
    endtask

    // phases of random settings, each a few whole frames of random pixels with
    // the odd restart, missing frame_start or phase cut in mid-frame
    task automatic test_random_traffic(input int n_items, input bit allow_idle);
        int sent;
        int frames;
        int f;
        int k;
        int w;
        int h;
        bit fs;
        bit first;
        bit cut;
        sent = 0;
        while (sent < n_items)
        begin
            wait_idle();
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            set_kernel(rand_weight_row(), rand_weight_row(), rand_weight_row(), rand_bias(),
                       rand_dim(), rand_dim());
            w      = eff_dim(width_word, MAX_WIDTH_DEF);
            h      = eff_dim(height_word, MAX_HEIGHT_DEF);
            frames = $urandom_range(1, 3);
            first  = 1'b1;
            cut    = 1'b0;
            f      = 0;
            while (f < frames && sent < n_items && !cut)
            begin
                for (k = 0; k < w * h && sent < n_items && !cut; k++)
                begin
                    // a new setting always starts on a fresh frame so no line
                    // store entry is read before it is written
                    if (k == 0)
                        fs = first || ($urandom_range(0, 2) != 0);
                    else
                        fs = ($urandom_range(0, 149) == 0);
                    send_pixel(rand_pixel(), fs);
                    first = 1'b0;
                    sent++;
                    cut = ($urandom_range(0, 299) == 0);
                end
                f++;
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        pix_if.valid       = 1'b0;
        pix_if.pixel       = '0;
        pix_if.frame_start = 1'b0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = CFG_WEIGHTS_ROW0;
        cfg_if.data        = '0;
        clear_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_rounding_and_wrap();
        test_saturation_extremes();
        test_resize_midframe();
        test_frame_restart();
        test_size_clamp();
        test_random_traffic(120, 1'b1);
        // closing stretch runs flat out on both sides
        idle_on = 1'b0;
        test_random_traffic(40, 1'b0);

        wait_idle();
        $display("run covered %0d pixels, %0d results, %0d frame ends, %0d register writes",
                 pixels_sent, results_seen, frame_ends, cfg_writes);
        $display("also exercised: clamped and maximum sizes, mid-frame resize, restarts, %0d errors",
                 err_count);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
